>>> src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and widths of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned LOC_W    = 7;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LOC_W-1:0]  loc;
    logic [DATA_W-1:0] val;
  } ple_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_val;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } ple_res_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR_DN,
    RD_PTR_UP,
    RD_LOC
  } ple_rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOC_VAL,
    WR_PTR_RD
  } ple_wr_sel_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CNT,
    PTR_LOC,
    PTR_DEC,
    PTR_INC
  } ple_ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } ple_cnt_op_e;

  // controller to datapath
  typedef struct packed {
    logic                latch;
    ple_rd_sel_e         rd_sel;
    ple_wr_sel_e         wr_sel;
    ple_ptr_op_e         ptr_op;
    ple_cnt_op_e         cnt_op;
    logic                finish;
    logic [STATUS_W-1:0] status;
    logic                use_rd;
  } ple_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              loc_gt_cnt;
    logic              loc_ge_cnt;
    logic              full;
    logic              ptr_gt_loc;
    logic              ptr_inc_lt_cnt;
  } ple_sts_t;

endpackage

>>> src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer of the list engine: decodes a request and steps the shift loop.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ple_pkg::ple_sts_t sts_i,
  output ple_pkg::ple_cmd_t cmd_o
);
  import ple_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_INS_CHK = 3'd2;
  localparam logic [2:0] S_INS_WR  = 3'd3;
  localparam logic [2:0] S_REM_CHK = 3'd4;
  localparam logic [2:0] S_REM_WR  = 3'd5;
  localparam logic [2:0] S_GET     = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.func)
          FN_INSERT: begin
            if (sts_i.loc_gt_cnt) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_BAD_INDEX;
              state_d      = S_IDLE;
            end else if (sts_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_FULL;
              state_d      = S_IDLE;
            end else begin
              cmd_o.ptr_op = PTR_CNT;
              state_d      = S_INS_CHK;
            end
          end
          FN_REMOVE: begin
            if (sts_i.loc_ge_cnt) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_BAD_INDEX;
              state_d      = S_IDLE;
            end else begin
              cmd_o.ptr_op = PTR_LOC;
              state_d      = S_REM_CHK;
            end
          end
          FN_SET: begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
            if (sts_i.loc_ge_cnt) begin
              cmd_o.status = ST_BAD_INDEX;
            end else begin
              cmd_o.status = ST_OK;
              cmd_o.wr_sel = WR_LOC_VAL;
            end
          end
          FN_GET: begin
            if (sts_i.loc_ge_cnt) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_BAD_INDEX;
              state_d      = S_IDLE;
            end else begin
              cmd_o.rd_sel = RD_LOC;
              state_d      = S_GET;
            end
          end
          FN_CLEAR: begin
            cmd_o.cnt_op = CNT_CLR;
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_OK;
            state_d      = S_IDLE;
          end
          default: begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_BAD_INDEX;
            state_d      = S_IDLE;
          end
        endcase
      end
      // walk from the tail down to the insert position
      S_INS_CHK: begin
        if (sts_i.ptr_gt_loc) begin
          cmd_o.rd_sel = RD_PTR_DN;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_sel = WR_LOC_VAL;
          cmd_o.cnt_op = CNT_INC;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_OK;
          state_d      = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_sel = WR_PTR_RD;
        cmd_o.ptr_op = PTR_DEC;
        state_d      = S_INS_CHK;
      end
      // pull later entries down one place
      S_REM_CHK: begin
        if (sts_i.ptr_inc_lt_cnt) begin
          cmd_o.rd_sel = RD_PTR_UP;
          state_d      = S_REM_WR;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_OK;
          state_d      = S_IDLE;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_sel = WR_PTR_RD;
        cmd_o.ptr_op = PTR_INC;
        state_d      = S_REM_CHK;
      end
      S_GET: begin
        cmd_o.use_rd = 1'b1;
        cmd_o.finish = 1'b1;
        cmd_o.status = ST_OK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Datapath of the list engine: entry storage, count, walk pointer, result.
// ----------------------------------------------------------------------------
module ple_dp #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ple_pkg::ple_req_t req_i,
  input  ple_pkg::ple_cmd_t cmd_i,
  output ple_pkg::ple_sts_t sts_o,
  output logic              done_o,
  output ple_pkg::ple_res_t res_o
);
  import ple_pkg::*;

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > LOC_W) ? CNT_W : LOC_W;

  logic [DATA_W-1:0] entries_q [CAPACITY];
  logic [DATA_W-1:0] rd_q;

  logic [FUNC_W-1:0] func_q;
  logic [LOC_W-1:0]  loc_q;
  logic [DATA_W-1:0] val_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W:0]   ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic [CMP_W-1:0] loc_ext, cnt_ext, ptr_ext, cnt_d_ext;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  ple_res_t res_d, res_q;
  logic     done_q;

  assign loc_ext   = CMP_W'(loc_q);
  assign cnt_ext   = CMP_W'(count_q);
  assign ptr_ext   = CMP_W'(ptr_q);
  assign cnt_d_ext = CMP_W'(count_d);
  assign ptr_inc   = {1'b0, ptr_q} + 1'b1;
  assign ptr_dec   = ptr_q - 1'b1;

  assign sts_o.func           = func_q;
  assign sts_o.loc_gt_cnt     = (loc_ext > cnt_ext);
  assign sts_o.loc_ge_cnt     = (loc_ext >= cnt_ext);
  assign sts_o.full           = (count_q == CNT_W'(CAPACITY));
  assign sts_o.ptr_gt_loc     = (ptr_ext > loc_ext);
  assign sts_o.ptr_inc_lt_cnt = (ptr_inc < {1'b0, count_q});

  always_comb begin
    re    = 1'b1;
    raddr = ptr_dec[AW-1:0];
    unique case (cmd_i.rd_sel)
      RD_PTR_DN: raddr = ptr_dec[AW-1:0];
      RD_PTR_UP: raddr = ptr_inc[AW-1:0];
      RD_LOC:    raddr = loc_ext[AW-1:0];
      default:   re    = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = ptr_q[AW-1:0];
    wdata = rd_q;
    unique case (cmd_i.wr_sel)
      WR_LOC_VAL: begin
        waddr = loc_ext[AW-1:0];
        wdata = val_q;
      end
      WR_PTR_RD: begin
        waddr = ptr_q[AW-1:0];
        wdata = rd_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      entries_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= entries_q[raddr];
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_CNT: ptr_d = count_q;
      PTR_LOC: ptr_d = loc_ext[CNT_W-1:0];
      PTR_DEC: ptr_d = ptr_dec;
      PTR_INC: ptr_d = ptr_inc[CNT_W-1:0];
      default: ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + 1'b1;
      CNT_DEC: count_d = count_q - 1'b1;
      CNT_CLR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  always_comb begin
    res_d.status   = cmd_i.status;
    res_d.read_val = cmd_i.use_rd ? rd_q : '0;
    res_d.count    = cnt_d_ext[COUNT_W-1:0];
    res_d.is_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= req_i.func;
      loc_q  <= req_i.loc;
      val_q  <= req_i.val;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to CAPACITY 64-bit words with positional insert/remove.
// ----------------------------------------------------------------------------
// A request (func, loc, val on req_i) is taken at a clock edge with start high
// and busy low. Operations: insert, remove, set, get, clear. Each request
// yields exactly one result on res_o, shown for one cycle with done_o high;
// the receiver cannot stall, so the result must be captured in that cycle.
// busy drops in the cycle that done_o rises, so the next request may be
// accepted while the result is on the ports.
// Set, clear and any rejected request finish in the decode step; get reads
// the entry and then finishes; insert or remove moves up to CAPACITY - 1
// entries one at a time, each read in the check state and written back in
// the write state, through separate read and write ports on the storage.
// A new request is not taken until the last one is through; the next one
// can be taken at the edge that ends the result cycle.
// Reset empties the list (count zero); storage contents are not cleared,
// as only positions below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ple_pkg::ple_req_t req_i,
  output logic              done_o,
  output ple_pkg::ple_res_t res_o
);
  import ple_pkg::*;

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // a finished request always returns the controller to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted request did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_OK) |-> (res_o.read_val == '0))
    else $error("rejected request returned data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && CAPACITY < 128) |-> (res_o.is_empty == (res_o.count == '0)))
    else $error("empty flag disagrees with count");

endmodule

>>> tb/tb_positional_list_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine. Requests are sent in
// bursts with random gaps. A shadow list predicts every result, and each
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * CAP + 8;
  localparam int unsigned RANDOM_REQS  = 2000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  ple_req_t req_i  = '0;
  logic     done_o;
  ple_res_t res_o;

  // shadow copy of the list contents
  logic [DATA_W-1:0] shadow_words [CAP];
  int unsigned       shadow_len  = 0;
  ple_res_t          pending_results [$];
  ple_res_t          oldest_result;
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left  = 0;
  bit                pacing_on   = 1'b1;

  positional_list_engine_unit #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // applies one request to the shadow list and returns the result it yields
  function automatic ple_res_t apply_list_op(ple_req_t rq);
    ple_res_t    r;
    int unsigned pos;
    int unsigned i;
    r        = '0;
    r.status = ST_OK;
    pos      = 32'(rq.loc);
    case (rq.func)
      FN_INSERT: begin
        if (pos > shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[pos] = rq.val;
          shadow_len++;
        end
      end
      FN_REMOVE: begin
        if (pos >= shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_len--;
        end
      end
      FN_SET: begin
        if (pos >= shadow_len) r.status = ST_BAD_INDEX;
        else shadow_words[pos] = rq.val;
      end
      FN_GET: begin
        if (pos >= shadow_len) r.status = ST_BAD_INDEX;
        else r.read_val = shadow_words[pos];
      end
      FN_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        r.status = ST_BAD_INDEX;
      end
    endcase
    r.count    = shadow_len[COUNT_W-1:0];
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_W-1){1'b0}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // bursts of requests with random gaps, now and then a long one
  task automatic pace();
    int unsigned gap;
    if (!pacing_on) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 7) == 0) gap = $urandom_range(1, 2 * CAP + 4);
        else gap = $urandom_range(1, 6);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // start stays high on return so back-to-back requests need no toggle
  task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [LOC_W-1:0] lc,
                          input logic [DATA_W-1:0] vl);
    ple_req_t rq;
    pace();
    rq.func = fn;
    rq.loc  = lc;
    rq.val  = vl;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_list_op(rq));
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending: %p", $time, res_o);
      end else begin
        oldest_result = pending_results.pop_front();
        if (res_o.status !== oldest_result.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time,
                   oldest_result.status, res_o.status);
        end
        if (res_o.read_val !== oldest_result.read_val) begin
          error_count++;
          $display("%0t: read_val expected %h actual %h", $time,
                   oldest_result.read_val, res_o.read_val);
        end
        if (res_o.count !== oldest_result.count) begin
          error_count++;
          $display("%0t: count expected %0d actual %0d", $time,
                   oldest_result.count, res_o.count);
        end
        if (res_o.is_empty !== oldest_result.is_empty) begin
          error_count++;
          $display("%0t: is_empty expected %b actual %b", $time,
                   oldest_result.is_empty, res_o.is_empty);
        end
      end
    end
  end

  task automatic test_empty_list();
    send_req(FN_GET, 7'd0, '0);
    send_req(FN_REMOVE, 7'd0, '0);
    send_req(FN_SET, 7'd0, '1);
    send_req(FN_INSERT, 7'd1, '1);
    send_req(FN_INSERT, 7'h7F, '1);
  endtask

  task automatic test_basic_ops();
    send_req(FN_INSERT, 7'd0, '1);
    send_req(FN_INSERT, 7'd1, '0);
    send_req(FN_INSERT, 7'd0, 64'hA5A5_5A5A_0F0F_F0F0);
    send_req(FN_INSERT, 7'd1, 64'h8000_0000_0000_0001);
    send_req(FN_INSERT, 7'd6, 64'h1234);
    send_req(FN_GET, 7'd0, '0);
    send_req(FN_GET, 7'd1, '0);
    send_req(FN_GET, 7'd2, '0);
    send_req(FN_GET, 7'd3, '0);
    send_req(FN_SET, 7'd3, 64'hDEAD_BEEF_CAFE_F00D);
    send_req(FN_GET, 7'd3, '0);
    send_req(FN_SET, 7'd4, '1);
    send_req(FN_GET, 7'd4, '0);
    send_req(FN_GET, 7'h7F, '0);
    send_req(FN_REMOVE, 7'd1, '0);
    send_req(FN_REMOVE, 7'd2, '0);
    send_req(FN_REMOVE, 7'd2, '0);
    send_req(FN_GET, 7'd1, '0);
    send_req(FN_CLEAR, 7'h55, '1);
    send_req(FN_GET, 7'd0, '0);
  endtask

  // the list must come back fully empty after its last entry goes
  task automatic test_remove_only_entry();
    send_req(FN_INSERT, 7'd0, 64'h0123_4567_89AB_CDEF);
    send_req(FN_REMOVE, 7'd0, '0);
    send_req(FN_GET, 7'd0, '0);
    send_req(FN_REMOVE, 7'd0, '0);
    send_req(FN_INSERT, 7'd0, 64'hFEDC_BA98_7654_3210);
    send_req(FN_GET, 7'd0, '0);
  endtask

  task automatic test_unknown_funcs();
    send_req(3'd5, 7'd0, '1);
    send_req(3'd6, 7'h2A, '0);
    send_req(3'd7, 7'h7F, '1);
    send_req(FN_GET, 7'd0, '0);
  endtask

  task automatic test_full_list();
    send_req(FN_CLEAR, 7'd0, '0);
    while (shadow_len < CAP) send_req(FN_INSERT, shadow_len[LOC_W-1:0], rand_word());
    send_req(FN_INSERT, CAP[LOC_W-1:0], '1);
    send_req(FN_INSERT, 7'd0, '1);
    send_req(FN_INSERT, 7'd65, '1);
    send_req(FN_GET, 7'd63, '0);
    send_req(FN_GET, 7'd64, '0);
    send_req(FN_REMOVE, 7'd64, '0);
    send_req(FN_REMOVE, 7'd0, '0);
    send_req(FN_INSERT, 7'd0, '1);
    send_req(FN_GET, 7'd0, '0);
    send_req(FN_REMOVE, 7'd63, '0);
    send_req(FN_GET, 7'd62, '0);
  endtask

  // phases that grow, shrink and churn the list; most positions are in range
  task automatic test_random_ops(input int unsigned n_reqs);
    int unsigned      k;
    int unsigned      w;
    int unsigned      phase;
    int unsigned      grow_w;
    logic [FUNC_W-1:0] fn;
    logic [LOC_W-1:0]  lc;
    for (k = 0; k < n_reqs; k++) begin
      pacing_on = (k % 500) < 400;
      phase     = (k / 150) % 3;
      grow_w    = (phase == 0) ? 55 : (phase == 1) ? 15 : 35;
      w         = $urandom_range(0, 99);
      if (w < grow_w) fn = FN_INSERT;
      else if (w < 70) fn = FN_REMOVE;
      else if (w < 83) fn = FN_SET;
      else if (w < 96) fn = FN_GET;
      else if (w < 98) fn = FUNC_W'($urandom_range(5, 7));
      else if (phase == 2) fn = FN_CLEAR;
      else fn = FN_GET;
      if ($urandom_range(0, 9) == 0) lc = LOC_W'($urandom_range(0, 127));
      else if (fn == FN_INSERT) lc = LOC_W'($urandom_range(0, shadow_len));
      else if (shadow_len == 0) lc = 7'd0;
      else lc = LOC_W'($urandom_range(0, shadow_len - 1));
      send_req(fn, lc, rand_word());
    end
    pacing_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_basic_ops();
    test_remove_only_entry();
    test_unknown_funcs();
    test_full_list();
    wait_all_results();
    test_random_ops(RANDOM_REQS);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/ple_pkg.sv
src/ple_ctrl.sv
src/ple_dp.sv
src/positional_list_engine_unit.sv
tb/tb_positional_list_engine_unit.sv
